>>> hw/rtl/eets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eets_pkg
// Types and codes shared by the serial EEPROM transaction sequencer.
// ----------------------------------------------------------------------------
package eets_pkg;

  localparam int unsigned ADDR_W = 15;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned POLL_W = 16;
  localparam int unsigned TMO_W  = 8;

  localparam logic [TMO_W-1:0]  POLL_TIMEOUT_RST = 8'd50;
  localparam logic [POLL_W-1:0] POLL_MAX         = 16'hFFFF;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_ABORT  = 3'd2,
    REQ_XFER   = 3'd3,
    REQ_POLL   = 3'd4,
    REQ_TICK   = 3'd5,
    REQ_STATUS = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RD_ADDR = 3'd1,
    PH_RD_DATA = 3'd2,
    PH_WR_SEND = 3'd3,
    PH_POLL    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ACC_OK      = 2'd0,
    ACC_BUSY    = 2'd1,
    ACC_INVALID = 2'd2
  } acc_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_SEND_ADDR = 3'd1,
    CMD_START_RD  = 3'd2,
    CMD_SEND_PAGE = 3'd3,
    CMD_ABORT     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    FAIL_NONE    = 2'd0,
    FAIL_NAK     = 2'd1,
    FAIL_TIMEOUT = 2'd2
  } fail_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ADDR_W-1:0] mem_addr;
    logic [LEN_W-1:0]  length;
    logic              transfer_ok;
    logic              device_ready;
  } eets_req_t;

  typedef struct packed {
    phase_e            phase;
    logic [LEN_W-1:0]  pending_len;
    logic [POLL_W-1:0] poll_elapsed;
    logic              rd_done;
    logic              wr_ok;
    fail_e             fail;
  } eets_state_t;

  typedef struct packed {
    acc_e              accept_status;
    cmd_e              bus_cmd;
    logic [ADDR_W-1:0] bus_addr;
    logic [LEN_W-1:0]  bus_len;
    logic              busy;
    logic              read_done;
    logic              write_ok;
    fail_e             fail_code;
  } eets_result_t;

endpackage

>>> hw/rtl/eets_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eets_step
// Combinational update for one item: request checks, phase transitions,
// completion flags and the result fields.
// ----------------------------------------------------------------------------
module eets_step import eets_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = 64,
  parameter int unsigned TOTAL_BYTES = 32768
) (
  input  eets_req_t          req_i,
  input  eets_state_t        state_i,
  input  logic [TMO_W-1:0]   poll_timeout_i,
  output eets_state_t        state_o,
  output eets_result_t       result_o
);

  // PAGE_BYTES is a power of two, so the page offset is the low address bits.
  localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int unsigned SUM_W     = LEN_W + 1;
  localparam logic [SUM_W-1:0] TOTAL_C = SUM_W'(TOTAL_BYTES);
  localparam logic [SUM_W-1:0] PAGE_C  = SUM_W'(PAGE_BYTES);

  logic [SUM_W-1:0] end_addr;
  logic [SUM_W-1:0] page_end;
  logic [SUM_W-1:0] len_ext;
  logic             len_zero;
  logic             rd_bad;
  logic             wr_bad;
  logic             timed_out;
  eets_state_t      nxt;
  eets_result_t     res;

  assign len_ext  = {1'b0, req_i.length};
  assign end_addr = {{(SUM_W-ADDR_W){1'b0}}, req_i.mem_addr} + len_ext;
  assign page_end = {{(SUM_W-PAGE_BITS){1'b0}}, req_i.mem_addr[PAGE_BITS-1:0]} + len_ext;
  assign len_zero = (req_i.length == '0);
  assign rd_bad   = len_zero || (end_addr > TOTAL_C);
  assign wr_bad   = rd_bad || (len_ext > PAGE_C) || (page_end > PAGE_C);
  assign timed_out = state_i.poll_elapsed > {{(POLL_W-TMO_W){1'b0}}, poll_timeout_i};

  always_comb begin
    nxt = state_i;
    res = '{accept_status: ACC_OK, bus_cmd: CMD_NONE, bus_addr: '0, bus_len: '0,
            busy: 1'b0, read_done: 1'b0, write_ok: 1'b0, fail_code: FAIL_NONE};

    unique case (req_i.req_type)
      REQ_READ: begin
        if (state_i.phase != PH_IDLE) begin
          res.accept_status = ACC_BUSY;
        end else if (rd_bad) begin
          res.accept_status = ACC_INVALID;
        end else begin
          nxt.pending_len = req_i.length;
          nxt.rd_done     = 1'b0;
          nxt.phase       = PH_RD_ADDR;
          res.bus_cmd     = CMD_SEND_ADDR;
          res.bus_addr    = req_i.mem_addr;
        end
      end
      REQ_WRITE: begin
        if (state_i.phase != PH_IDLE) begin
          res.accept_status = ACC_BUSY;
        end else if (wr_bad) begin
          res.accept_status = ACC_INVALID;
        end else begin
          nxt.wr_ok    = 1'b0;
          nxt.fail     = FAIL_NONE;
          nxt.phase    = PH_WR_SEND;
          res.bus_cmd  = CMD_SEND_PAGE;
          res.bus_addr = req_i.mem_addr;
          res.bus_len  = req_i.length;
        end
      end
      REQ_ABORT: begin
        res.bus_cmd     = CMD_ABORT;
        nxt.phase       = PH_IDLE;
        nxt.pending_len = '0;
        nxt.wr_ok       = 1'b0;
      end
      REQ_XFER: begin
        priority if (state_i.phase == PH_RD_ADDR) begin
          if (req_i.transfer_ok) begin
            nxt.phase   = PH_RD_DATA;
            res.bus_cmd = CMD_START_RD;
            res.bus_len = state_i.pending_len;
          end else begin
            nxt.phase = PH_IDLE;
          end
        end else if (state_i.phase == PH_RD_DATA) begin
          nxt.phase   = PH_IDLE;
          nxt.rd_done = req_i.transfer_ok;
        end else if (state_i.phase == PH_WR_SEND) begin
          if (req_i.transfer_ok) begin
            nxt.phase        = PH_POLL;
            nxt.poll_elapsed = '0;
          end else begin
            nxt.wr_ok = 1'b0;
            nxt.fail  = FAIL_NAK;
            nxt.phase = PH_IDLE;
          end
        end else begin
          nxt = state_i;
        end
      end
      REQ_POLL: begin
        if (state_i.phase == PH_POLL) begin
          priority if (req_i.device_ready) begin
            nxt.wr_ok = 1'b1;
            nxt.phase = PH_IDLE;
          end else if (timed_out) begin
            nxt.wr_ok = 1'b0;
            nxt.fail  = FAIL_TIMEOUT;
            nxt.phase = PH_IDLE;
          end else begin
            nxt = state_i;
          end
        end
      end
      REQ_TICK: begin
        if (state_i.phase == PH_POLL && state_i.poll_elapsed != POLL_MAX) begin
          nxt.poll_elapsed = state_i.poll_elapsed + POLL_W'(1);
        end
      end
      default: begin
        // Status query is handled below; the unused code leaves everything as is.
      end
    endcase

    res.busy      = (nxt.phase != PH_IDLE);
    res.read_done = nxt.rd_done;
    res.write_ok  = nxt.wr_ok;
    res.fail_code = nxt.fail;

    // A status query reports the read completion once and then clears it.
    if (req_i.req_type == REQ_STATUS) begin
      nxt.rd_done = 1'b0;
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

>>> hw/rtl/i2c_eeprom_transaction_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_transaction_sequencer
// Serial EEPROM transaction sequencer with page-write acknowledge polling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event item: a read or
//   page-write request, abort, transfer done, ready poll, ms tick or status
//   query. Output channel (out_valid_o / out_stall_i) returns exactly one
//   result item per input item, in order.
//   The cfg channel writes the poll timeout in ms; it is always ready and is
//   meant to be written only while no item is in flight.
//   The item waits in the input register, and the update logic loads the
//   result register when the output is free. Throughput is one item per
//   cycle while the receiver does not stall; the sequencer state is updated
//   in the same cycle the result register loads.
//   While the receiver stalls, the result register holds and the input
//   register can still take one more item; after that in_stall_o is raised.
//   Reset returns the block to idle with all flags cleared and the timeout
//   at 50 ms.
// ----------------------------------------------------------------------------
module i2c_eeprom_transaction_sequencer import eets_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = 64,
  parameter int unsigned TOTAL_BYTES = 32768
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TMO_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        req_type_i,
  input  logic [ADDR_W-1:0] mem_addr_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic              transfer_ok_i,
  input  logic              device_ready_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        accept_status_o,
  output logic [2:0]        bus_cmd_o,
  output logic [ADDR_W-1:0] bus_addr_o,
  output logic [LEN_W-1:0]  bus_len_o,
  output logic              busy_res_o,
  output logic              read_done_o,
  output logic              write_ok_o,
  output logic [1:0]        fail_code_o
);

  logic             in_valid_q;
  eets_req_t        req_q;
  logic             out_valid_q;
  eets_result_t     res_q;
  eets_state_t      state_q;
  eets_state_t      state_d;
  eets_result_t     res_d;
  logic [TMO_W-1:0] timeout_q;
  logic             out_free;
  logic             step_fire;
  logic             in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_fire  = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= POLL_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= '{req_type: req_type_i, mem_addr: mem_addr_i, length: length_i,
                 transfer_ok: transfer_ok_i, device_ready: device_ready_i};
    end
  end

  eets_step #(
    .PAGE_BYTES  (PAGE_BYTES),
    .TOTAL_BYTES (TOTAL_BYTES)
  ) u_step (
    .req_i          (req_q),
    .state_i        (state_q),
    .poll_timeout_i (timeout_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, pending_len: '0, poll_elapsed: '0,
                   rd_done: 1'b0, wr_ok: 1'b0, fail: FAIL_NONE};
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accept_status_o = res_q.accept_status;
  assign bus_cmd_o       = res_q.bus_cmd;
  assign bus_addr_o      = res_q.bus_addr;
  assign bus_len_o       = res_q.bus_len;
  assign busy_res_o      = res_q.busy;
  assign read_done_o     = res_q.read_done;
  assign write_ok_o      = res_q.write_ok;
  assign fail_code_o     = res_q.fail_code;

`ifndef NO_ASSERTIONS
  // The busy bit of a waiting result matches the phase, since no item
  // updates the state while the result register is occupied and stalled.
  a_busy_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (busy_res_o == (state_q.phase != PH_IDLE)))
    else $error("busy_res_o disagrees with the sequencer phase");

  a_ok_and_fail_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(write_ok_o && (fail_code_o != FAIL_NONE)))
    else $error("write_ok and a failure code reported together");

  a_abort_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (bus_cmd_o == CMD_ABORT)) |-> !busy_res_o)
    else $error("abort result reports a busy sequencer");

  a_send_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((bus_cmd_o == CMD_SEND_ADDR) || (bus_cmd_o == CMD_SEND_PAGE)
     || (bus_cmd_o == CMD_START_RD))) |-> busy_res_o)
    else $error("bus command issued without a transaction in progress");
`endif

endmodule
